/* rtl/pcm_byte_order_detector_macros.svh */
// Assertion macros used by the top block of the byte order detector.
`ifndef PCM_BYTE_ORDER_DETECTOR_MACROS_SVH
`define PCM_BYTE_ORDER_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PBOD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PBOD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pbod_pkg.sv */
package pbod_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int SUM_WIDTH_DEFAULT = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        VERDICT_NATIVE       = 2'd0,
        VERDICT_SWAPPED      = 2'd1,
        VERDICT_INCONCLUSIVE = 2'd2,
        VERDICT_READ_FAIL    = 2'd3
    } verdict_t;

    // Handshake between the decision queue and the back end.
    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

/* rtl/pcm_byte_order_detector.sv */
// The byte order detector takes one left-channel audio word per cycle while s_ready is high
// and decides, at the end of each window, whether the drive delivers words in native or
// swapped byte order. For the word as given and for its byte-swapped form it keeps a
// saturating sum of magnitudes, a saturating sum of sample-to-sample change magnitudes and the
// last word. On the last word of a window (s_window_end) the four sums, including that word,
// are handed to a decision engine and all running state clears, so the next window may start
// in the very next cycle. The verdict is swapped when the change-to-level ratio of the native
// form exceeds that of the swapped form by more than one half, native when it falls short by
// more than one half, and inconclusive otherwise or when either level sum is zero;
// m_swap_needed is high only for a swapped verdict. A word with s_read_error set is ignored,
// ends the window and yields the read failure verdict. Throughput is one word per cycle while
// the input is not stalled. The decision engine uses a radix-2 shift-add multiplier. A full
// decision takes the job in ST_IDLE, multiplies in ST_MUL, compares in ST_CMP and holds the
// result word in ST_OUT, while read failures and zero-level windows go from ST_IDLE straight
// to ST_OUT. The engine takes no new window until its result word has been taken. A two-entry
// queue buffers finished windows, and the input stalls only when both entries are waiting,
// that is when windows end faster than the engine can decide them or when the result channel
// is held off.
`include "pcm_byte_order_detector_macros.svh"

module pcm_byte_order_detector #(
    parameter int SUM_WIDTH = pbod_pkg::SUM_WIDTH_DEFAULT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [pbod_pkg::SAMPLE_WIDTH-1:0] s_sample_word,
    input  logic                                     s_window_end,
    input  logic                                     s_read_error,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [1:0]                               m_verdict,
    output logic                                     m_swap_needed
);
    import pbod_pkg::*;

    localparam int JOB_W = 4 * SUM_WIDTH + 1;

    logic            accept;
    logic            window_done;
    logic            push;
    logic [JOB_W-1:0] push_data;
    logic [JOB_W-1:0] head_data;
    logic            pop;
    queue_status_t   q_status;
    verdict_t        verdict;

    // A word is taken whenever the queue has room for a possible window end.
    assign s_ready     = !q_status.full;
    assign accept      = s_valid && s_ready;
    assign window_done = accept && (s_window_end || s_read_error);

    // The front end accumulates the sums and emits one decision job per window.
    pbod_front #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_front (
        .clk         (aclk),
        .rstn        (aresetn),
        .accept      (accept),
        .sample_word (s_sample_word),
        .window_end  (s_window_end),
        .read_error  (s_read_error),
        .push        (push),
        .push_data   (push_data)
    );

    // The queue lets the front keep accumulating while the back end decides.
    pbod_queue #(
        .DATA_WIDTH (JOB_W),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .clk       (aclk),
        .rstn      (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .status    (q_status),
        .head_data (head_data)
    );

    // The back end runs the exact cross-multiplied comparison and holds the result word.
    pbod_back #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_back (
        .clk         (aclk),
        .rstn        (aresetn),
        .q_status    (q_status),
        .q_data      (head_data),
        .q_pop       (pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_verdict (verdict)
    );

    assign m_verdict     = verdict;
    assign m_swap_needed = (verdict == VERDICT_SWAPPED);

    // A word that ends a window must leave a job behind in the queue.
    `PBOD_ASSERT_NEXT(a_job_queued, aclk, aresetn, window_done, q_status.valid, "no job queued")
    // The back end only takes a new job once the previous result word is gone.
    `PBOD_ASSERT_NOW(a_pop_when_free, aclk, aresetn, pop, !m_valid, "pop with result pending")
    // A full queue must stall the input channel.
    `PBOD_ASSERT_NOW(a_full_stalls, aclk, aresetn, q_status.full, !s_ready, "input open when full")

endmodule

/* rtl/pbod_front.sv */
module pbod_front #(
    parameter int SUM_WIDTH = pbod_pkg::SUM_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rstn,
    input  logic                                  accept,
    input  logic signed [pbod_pkg::SAMPLE_WIDTH-1:0] sample_word,
    input  logic                                  window_end,
    input  logic                                  read_error,
    output logic                                  push,
    output logic [4*SUM_WIDTH:0]                  push_data
);
    import pbod_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    logic [SUM_WIDTH-1:0] nat_level_reg, nat_change_reg, swp_level_reg, swp_change_reg;
    logic [SUM_WIDTH-1:0] nat_level_next, nat_change_next, swp_level_next, swp_change_next;
    logic signed [SW-1:0] prev_nat_reg, prev_swp_reg;
    logic signed [SW-1:0] swp_word;

    // Magnitude of a 17-bit signed value; the largest result, 65535, fits 16 bits.
    function automatic logic [SW-1:0] mag17(input logic signed [SW:0] v);
        logic [SW:0] a;
        a = v[SW] ? (~v + 1'b1) : v;
        return a[SW-1:0];
    endfunction

    function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] acc,
                                                     input logic [SW-1:0] v);
        logic [SUM_WIDTH:0] s;
        s = {1'b0, acc} + {{(SUM_WIDTH + 1 - SW){1'b0}}, v};
        return s[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : s[SUM_WIDTH-1:0];
    endfunction

    always_comb begin
        swp_word        = {sample_word[7:0], sample_word[SW-1:8]};
        nat_level_next  = sat_add(nat_level_reg, mag17({sample_word[SW-1], sample_word}));
        swp_level_next  = sat_add(swp_level_reg, mag17({swp_word[SW-1], swp_word}));
        nat_change_next = sat_add(nat_change_reg,
            mag17({sample_word[SW-1], sample_word} - {prev_nat_reg[SW-1], prev_nat_reg}));
        swp_change_next = sat_add(swp_change_reg,
            mag17({swp_word[SW-1], swp_word} - {prev_swp_reg[SW-1], prev_swp_reg}));
    end

    assign push      = accept && (window_end || read_error);
    assign push_data = {read_error, nat_level_next, nat_change_next,
                        swp_level_next, swp_change_next};

    always_ff @(posedge clk) begin
        if (!rstn || (accept && (window_end || read_error))) begin
            nat_level_reg  <= '0;
            nat_change_reg <= '0;
            swp_level_reg  <= '0;
            swp_change_reg <= '0;
            prev_nat_reg   <= '0;
            prev_swp_reg   <= '0;
        end else if (accept) begin
            nat_level_reg  <= nat_level_next;
            nat_change_reg <= nat_change_next;
            swp_level_reg  <= swp_level_next;
            swp_change_reg <= swp_change_next;
            prev_nat_reg   <= sample_word;
            prev_swp_reg   <= swp_word;
        end
    end

endmodule

/* rtl/pbod_queue.sv */
module pbod_queue #(
    parameter int DATA_WIDTH = 4 * pbod_pkg::SUM_WIDTH_DEFAULT + 1,
    parameter int DEPTH      = pbod_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rstn,
    input  logic                          push,
    input  logic [DATA_WIDTH-1:0]         push_data,
    input  logic                          pop,
    output pbod_pkg::queue_status_t       status,
    output logic [DATA_WIDTH-1:0]         head_data
);
    import pbod_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign head_data    = entries[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/pbod_back.sv */
module pbod_back #(
    parameter int SUM_WIDTH = pbod_pkg::SUM_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rstn,
    input  pbod_pkg::queue_status_t       q_status,
    input  logic [4*SUM_WIDTH:0]          q_data,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pbod_pkg::verdict_t            out_verdict
);
    import pbod_pkg::*;

    localparam int W     = SUM_WIDTH;
    localparam int CNT_W = $clog2(W);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic            job_fail;
    logic [W-1:0]    job_nl, job_nc, job_sl, job_sc;

    // Shift-add products: pn = nc*sl, pb = nl*sl, ps = sc*nl.
    logic [2*W-1:0]  cand_pn_reg, cand_pb_reg, cand_ps_reg;
    logic [2*W-1:0]  prod_pn_reg, prod_pb_reg, prod_ps_reg;
    logic [W-1:0]    mult_sl_reg, mult_nl_reg;
    logic [CNT_W-1:0] cnt_reg;
    verdict_t        verdict_reg;

    logic [2*W+1:0]  dbl_pn, dbl_ps, rhs, lhs;

    assign {job_fail, job_nl, job_nc, job_sl, job_sc} = q_data;

    assign q_pop       = (state_reg == ST_IDLE) && q_status.valid;
    assign out_valid   = (state_reg == ST_OUT);
    assign out_verdict = verdict_reg;

    always_comb begin
        dbl_pn = {1'b0, prod_pn_reg, 1'b0};
        dbl_ps = {1'b0, prod_ps_reg, 1'b0};
        rhs    = dbl_ps + {2'b00, prod_pb_reg};
        lhs    = dbl_pn + {2'b00, prod_pb_reg};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_status.valid) begin
                    if (job_fail || job_nl == '0 || job_sl == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (cnt_reg == CNT_W'(W - 1)) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: state_next = ST_OUT;
            ST_OUT: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk) begin
        unique case (state_reg)
            ST_IDLE: begin
                cnt_reg     <= '0;
                cand_pn_reg <= {{W{1'b0}}, job_nc};
                cand_pb_reg <= {{W{1'b0}}, job_nl};
                cand_ps_reg <= {{W{1'b0}}, job_sc};
                mult_sl_reg <= job_sl;
                mult_nl_reg <= job_nl;
                prod_pn_reg <= '0;
                prod_pb_reg <= '0;
                prod_ps_reg <= '0;
                if (job_fail) begin
                    verdict_reg <= VERDICT_READ_FAIL;
                end else begin
                    verdict_reg <= VERDICT_INCONCLUSIVE;
                end
            end
            ST_MUL: begin
                if (mult_sl_reg[0]) begin
                    prod_pn_reg <= prod_pn_reg + cand_pn_reg;
                    prod_pb_reg <= prod_pb_reg + cand_pb_reg;
                end
                if (mult_nl_reg[0]) begin
                    prod_ps_reg <= prod_ps_reg + cand_ps_reg;
                end
                cand_pn_reg <= cand_pn_reg << 1;
                cand_pb_reg <= cand_pb_reg << 1;
                cand_ps_reg <= cand_ps_reg << 1;
                mult_sl_reg <= mult_sl_reg >> 1;
                mult_nl_reg <= mult_nl_reg >> 1;
                cnt_reg     <= cnt_reg + 1'b1;
            end
            ST_CMP: begin
                if (dbl_pn > rhs) begin
                    verdict_reg <= VERDICT_SWAPPED;
                end else if (dbl_ps > lhs) begin
                    verdict_reg <= VERDICT_NATIVE;
                end else begin
                    verdict_reg <= VERDICT_INCONCLUSIVE;
                end
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

endmodule
